FILE: src/i2cms_pkg.sv
// shared types and constants for the i2c master bit sequencer
package i2cms_pkg;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0] BYTE_BITS       = 4'd8;

  typedef enum logic [2:0] {
    FN_START = 3'd0,
    FN_STOP  = 3'd1,
    FN_SEND  = 3'd2,
    FN_WACK  = 3'd3,
    FN_READ  = 3'd4,
    FN_ACK   = 3'd5,
    FN_NACK  = 3'd6
  } func_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3,
    PH_TX_LO, PH_TX_HI, PH_RX_HI, PH_RX_LO,
    PH_AK1, PH_AK2, PH_AK3, PH_AK4, PH_NK1, PH_NK2, PH_NK3,
    PH_WA1, PH_WA2, PH_WA_POLL, PH_WA_END
  } phase_e;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_missing;
  } result_t;

endpackage

FILE: src/i2cms_cmd_if.sv
// tick channel carrying the command fields and the sampled sda level
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] func;
  logic [7:0] tx_data;
  logic       send_ack;
  logic       sda_level;

  modport source (output valid, cmd_valid, func, tx_data, send_ack, sda_level,
                  input ready);
  modport sink   (input valid, cmd_valid, func, tx_data, send_ack, sda_level,
                  output ready);
endinterface

FILE: src/i2cms_res_if.sv
// result channel carrying the line levels and status of one tick
interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       ack_missing;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_data,
                  ack_missing, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_data,
                  ack_missing, output ready);
endinterface

FILE: src/i2cms_core.sv
// sequencer state and the per-tick step logic
module i2cms_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 step_i,
  input  logic                 cmd_valid_i,
  input  logic [2:0]           func_i,
  input  logic [7:0]           tx_data_i,
  input  logic                 send_ack_i,
  input  logic                 sda_level_i,
  output i2cms_pkg::result_t   result_o,
  output logic                 idle_o
);

  i2cms_pkg::phase_e phase_q, phase_d, ph_c, next_c;
  logic [2:0] act_q, act_d;
  logic [3:0] bit_q, bit_d, bit_inc;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d, wait_inc;
  logic       ackc_q, ackc_d;
  logic       tflag_q, tflag_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [7:0] tmo_q;
  logic       start_c;

  assign idle_o = (phase_q == i2cms_pkg::PH_IDLE);

  always_comb begin
    phase_d  = phase_q;
    act_d    = act_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    wait_d   = wait_q;
    ackc_d   = ackc_q;
    tflag_d  = tflag_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ph_c     = phase_q;
    next_c   = i2cms_pkg::PH_IDLE;
    start_c  = 1'b0;
    bit_inc  = '0;
    wait_inc = '0;
    result_o = '0;

    // command pickup, its first tick runs in the same step
    if (phase_q == i2cms_pkg::PH_IDLE && cmd_valid_i) begin
      case (func_i)
        i2cms_pkg::FN_START: begin
          start_c = 1'b1;
          ph_c    = i2cms_pkg::PH_ST1;
        end
        i2cms_pkg::FN_STOP: begin
          start_c = 1'b1;
          ph_c    = i2cms_pkg::PH_SP1;
        end
        i2cms_pkg::FN_SEND: begin
          start_c = 1'b1;
          shift_d = tx_data_i;
          ph_c    = i2cms_pkg::PH_TX_LO;
        end
        i2cms_pkg::FN_WACK: begin
          start_c = 1'b1;
          wait_d  = '0;
          tflag_d = 1'b0;
          ph_c    = i2cms_pkg::PH_WA1;
        end
        i2cms_pkg::FN_READ: begin
          start_c = 1'b1;
          shift_d = '0;
          ackc_d  = send_ack_i;
          ph_c    = i2cms_pkg::PH_RX_HI;
        end
        i2cms_pkg::FN_ACK: begin
          start_c = 1'b1;
          ph_c    = i2cms_pkg::PH_AK1;
        end
        i2cms_pkg::FN_NACK: begin
          start_c = 1'b1;
          ph_c    = i2cms_pkg::PH_NK1;
        end
        default: ;
      endcase
    end
    if (start_c) begin
      act_d = func_i;
      bit_d = '0;
    end

    if (ph_c == i2cms_pkg::PH_IDLE) begin
      result_o.scl_out = scl_d;
      result_o.sda_out = sda_d;
    end else begin
      result_o.busy_res = 1'b1;
      case (ph_c)
        i2cms_pkg::PH_ST1: begin
          sda_d = 1'b1; scl_d = 1'b1; next_c = i2cms_pkg::PH_ST2;
        end
        i2cms_pkg::PH_ST2: begin sda_d = 1'b0; next_c = i2cms_pkg::PH_ST3; end
        i2cms_pkg::PH_ST3: scl_d = 1'b0;
        i2cms_pkg::PH_SP1: begin sda_d = 1'b0; next_c = i2cms_pkg::PH_SP2; end
        i2cms_pkg::PH_SP2: begin scl_d = 1'b1; next_c = i2cms_pkg::PH_SP3; end
        i2cms_pkg::PH_SP3: begin
          sda_d = 1'b1;
          // a timed-out acknowledge wait finishes by pulling scl low
          next_c = (act_d == i2cms_pkg::FN_WACK) ? i2cms_pkg::PH_WA_END
                                                : i2cms_pkg::PH_IDLE;
        end
        i2cms_pkg::PH_TX_LO: begin
          sda_d = shift_d[7]; next_c = i2cms_pkg::PH_TX_HI;
        end
        i2cms_pkg::PH_TX_HI: begin scl_d = 1'b1; next_c = i2cms_pkg::PH_TX_LO; end
        i2cms_pkg::PH_RX_HI: begin scl_d = 1'b1; next_c = i2cms_pkg::PH_RX_LO; end
        i2cms_pkg::PH_RX_LO: begin scl_d = 1'b0; next_c = i2cms_pkg::PH_RX_HI; end
        i2cms_pkg::PH_AK1: begin sda_d = 1'b0; next_c = i2cms_pkg::PH_AK2; end
        i2cms_pkg::PH_AK2: begin scl_d = 1'b1; next_c = i2cms_pkg::PH_AK3; end
        i2cms_pkg::PH_AK3: begin scl_d = 1'b0; next_c = i2cms_pkg::PH_AK4; end
        i2cms_pkg::PH_AK4: sda_d = 1'b1;
        i2cms_pkg::PH_NK1: begin sda_d = 1'b1; next_c = i2cms_pkg::PH_NK2; end
        i2cms_pkg::PH_NK2: begin scl_d = 1'b1; next_c = i2cms_pkg::PH_NK3; end
        i2cms_pkg::PH_NK3: scl_d = 1'b0;
        i2cms_pkg::PH_WA1: begin sda_d = 1'b1; next_c = i2cms_pkg::PH_WA2; end
        i2cms_pkg::PH_WA2: begin scl_d = 1'b1; next_c = i2cms_pkg::PH_WA_POLL; end
        i2cms_pkg::PH_WA_POLL: next_c = i2cms_pkg::PH_WA_POLL;
        i2cms_pkg::PH_WA_END: scl_d = 1'b0;
        default: ;
      endcase
      result_o.scl_out = scl_d;
      result_o.sda_out = sda_d;

      // actions at the end of the half period, using the sampled sda
      if (ph_c == i2cms_pkg::PH_TX_HI) begin
        scl_d   = 1'b0;
        shift_d = {shift_d[6:0], 1'b0};
        bit_inc = bit_d + 4'd1;
        bit_d   = bit_inc;
        if (bit_inc >= i2cms_pkg::BYTE_BITS) begin
          sda_d  = 1'b1;
          next_c = i2cms_pkg::PH_IDLE;
        end
      end else if (ph_c == i2cms_pkg::PH_RX_HI) begin
        shift_d = {shift_d[6:0], sda_level_i};
      end else if (ph_c == i2cms_pkg::PH_RX_LO) begin
        bit_inc = bit_d + 4'd1;
        bit_d   = bit_inc;
        if (bit_inc >= i2cms_pkg::BYTE_BITS) begin
          rx_d   = shift_d;
          next_c = ackc_d ? i2cms_pkg::PH_AK1 : i2cms_pkg::PH_NK1;
        end
      end else if (ph_c == i2cms_pkg::PH_WA2 || ph_c == i2cms_pkg::PH_WA_POLL) begin
        if (!sda_level_i) begin
          next_c = i2cms_pkg::PH_WA_END;
        end else begin
          wait_inc = wait_d + 8'd1;
          wait_d   = wait_inc;
          if (wait_inc > tmo_q) begin
            tflag_d = 1'b1;
            next_c  = i2cms_pkg::PH_SP1;
          end else begin
            next_c  = i2cms_pkg::PH_WA_POLL;
          end
        end
      end

      phase_d = next_c;
      result_o.done_res = (next_c == i2cms_pkg::PH_IDLE);
    end

    result_o.rx_data     = rx_d;
    result_o.ack_missing = tflag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cms_pkg::PH_IDLE;
      act_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      ackc_q  <= 1'b0;
      tflag_q <= 1'b0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      act_q   <= act_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      ackc_q  <= ackc_d;
      tflag_q <= tflag_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

FILE: src/i2cms_out_reg.sv
// result register between the step logic and the result channel
module i2cms_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  i2cms_pkg::result_t result_i,
  output logic               room_o,
  i2cms_res_if.source        res_o
);

  logic               valid_q;
  i2cms_pkg::result_t data_q;

  // free when empty or when the held result leaves this cycle
  assign room_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.scl_out     = data_q.scl_out;
  assign res_o.sda_out     = data_q.sda_out;
  assign res_o.busy_res    = data_q.busy_res;
  assign res_o.done_res    = data_q.done_res;
  assign res_o.rx_data     = data_q.rx_data;
  assign res_o.ack_missing = data_q.ack_missing;

endmodule

FILE: src/i2c_master_bit_sequencer.sv
// top level of the i2c master bit sequencer
//
// Every transfer on cmd_i is one half-period tick of the bus. It carries an
// optional command (cmd_valid, func, tx_data, send_ack) and the sda level
// sampled at the end of that tick. A command is taken only while the
// sequencer is idle; the first tick of its pattern is the same transfer.
// Every tick produces exactly one result on res_o: scl and sda drive levels
// (1 = released), busy, done on the last tick of a sequence, the last
// received byte and the ack-missing flag.
// The result of a tick is registered: it sits in the output register in the
// cycle after its transfer. Throughput is one tick per cycle while the receiver
// takes results, set by the single step of the phase register per tick.
// cmd_i.ready is high while the output register is empty or is being read,
// so a stalled receiver holds the result and backs up the tick channel.
// The acknowledge timeout is written through cfg_we_i/cfg_wdata_i, by the user
// only while the block is idle; the block itself does not enforce this.
// Reset puts the sequencer idle with both lines released, the timeout at
// 250 and the output register empty.
module i2c_master_bit_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  i2cms_cmd_if.sink   cmd_i,
  i2cms_res_if.source res_o
);

  i2cms_pkg::result_t result;
  logic               room;
  logic               step;
  logic               idle;

  assign cmd_i.ready = room;
  assign step        = cmd_i.valid && room;

  i2cms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .cmd_valid_i (cmd_i.cmd_valid),
    .func_i      (cmd_i.func),
    .tx_data_i   (cmd_i.tx_data),
    .send_ack_i  (cmd_i.send_ack),
    .sda_level_i (cmd_i.sda_level),
    .result_o    (result),
    .idle_o      (idle)
  );

  i2cms_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .room_o   (room),
    .res_o    (res_o)
  );

  // a tick with no command while idle gives a non-busy result next cycle
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && idle && !cmd_i.cmd_valid) |=> (res_o.valid && !res_o.busy_res))
    else $error("idle tick produced a busy result");

  // done only ever marks the last tick of a busy sequence
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.done_res) |-> res_o.busy_res)
    else $error("done without busy");

  // an empty output register never holds back the tick channel
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> cmd_i.ready)
    else $error("tick channel stalled with empty output register");

endmodule
